/* src/burh_pkg.sv */
// shared types and constants for the bounded undo/redo history unit
package burh_pkg;

  // sizing of the history store and the payload
  localparam int HISTORY_DEPTH = 64;
  localparam int HANDLE_WIDTH  = 16;
  localparam int SIZE_WIDTH    = 32;
  localparam int IDX_W  = $clog2(HISTORY_DEPTH);
  localparam int CNT_W  = $clog2(HISTORY_DEPTH + 1);
  localparam int WRAP_W = CNT_W + 1;
  localparam int SUM_W  = 38;
  localparam int LIM_W  = 7;
  localparam int CMP_W  = (CNT_W > LIM_W) ? CNT_W : LIM_W;
  localparam int CFG_IDX_W = 2;

  // configuration reset values
  localparam logic [LIM_W-1:0] LIMIT_RESET    = LIM_W'(64);
  localparam logic [SUM_W-1:0] BUDGET_RESET   = '1;
  localparam logic [LIM_W-1:0] MIN_KEEP_RESET = LIM_W'(1);

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_HISTORY_LIMIT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BYTE_BUDGET   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_KEEP      = 2'd2;

  typedef enum logic [1:0] {
    OP_RESET  = 2'd0,
    OP_COMMIT = 2'd1,
    OP_UNDO   = 2'd2,
    OP_REDO   = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    STATUS_DONE    = 2'd0,
    STATUS_NO_UNDO = 2'd1,
    STATUS_NO_REDO = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_PUSH,
    S_TRIM,
    S_DROP,
    S_UNDO,
    S_REDO,
    S_REPLY
  } state_t;

  // one history entry: snapshot handle and its byte size
  typedef struct packed {
    logic [HANDLE_WIDTH-1:0] handle;
    logic [SIZE_WIDTH-1:0]   size;
  } entry_t;

endpackage

/* src/bounded_undo_redo_history_unit.sv */
// top level of the bounded undo/redo history unit
// One command is taken when start is high and busy is low; its single result
// beat appears on the result ports with done high for exactly one cycle and
// must be captured then, since the receiver cannot stall it. Busy stays high
// from acceptance through the result cycle: reset and refused undo/redo pass
// through decode and reply, a successful undo or redo adds its own state, and
// a commit runs push, trim and a drop/trim pair per dropped entry; when the
// past list was already full, the first drop comes before the push and needs
// no trim check. The next command can be taken in the cycle after done.
// Commit time is set by the trim loop, which reads the oldest entry's size
// from the past memory (one registered read) and subtracts it.
// Past and future entries live in single-port-write memories with one read
// port each and need no clearing after reset. Configuration writes are always
// ready and should be issued only while the unit is idle.
module bounded_undo_redo_history_unit
  import burh_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    start,
  output logic                    busy,
  input  logic [1:0]              opcode,
  input  logic [HANDLE_WIDTH-1:0] snapshot_handle,
  input  logic [SIZE_WIDTH-1:0]   snapshot_bytes,
  output logic                    done,
  output logic [1:0]              status,
  output logic [HANDLE_WIDTH-1:0] current_handle,
  output logic [SIZE_WIDTH-1:0]   current_bytes,
  output logic [CNT_W-1:0]        past_depth,
  output logic [CNT_W-1:0]        future_depth,
  output logic [SUM_W-1:0]        past_total_bytes,
  output logic [CNT_W-1:0]        dropped_count,
  input  logic                    cfg_valid,
  output logic                    cfg_ready,
  input  logic [CFG_IDX_W-1:0]    cfg_index,
  input  logic [SUM_W-1:0]        cfg_data
);

  state_t state, state_next;

  // configuration registers
  logic [LIM_W-1:0] history_limit;
  logic [SUM_W-1:0] byte_budget;
  logic [LIM_W-1:0] min_keep;

  // latched command
  op_t                     op;
  logic [HANDLE_WIDTH-1:0] new_handle;
  logic [SIZE_WIDTH-1:0]   new_bytes;

  // history state
  logic [IDX_W-1:0]        past_oldest;
  logic [CNT_W-1:0]        past_count;
  logic [SUM_W-1:0]        past_sum;
  logic [CNT_W-1:0]        future_count;
  entry_t                  current;
  logic [CNT_W-1:0]        dropped;
  status_t                 result_status;
  logic                    pushed;

  // memories
  entry_t past_mem   [HISTORY_DEPTH];
  entry_t future_mem [HISTORY_DEPTH];
  entry_t past_rdata, future_rdata;
  logic [IDX_W-1:0] past_raddr, future_raddr;
  logic past_we, future_we;

  // derived indexes and conditions
  logic [WRAP_W-1:0] tail_raw, newest_raw;
  logic [IDX_W-1:0]  tail_idx, newest_idx, oldest_inc;
  logic [CMP_W-1:0]  eff_limit;
  logic              past_full, future_full, trim_cond, undo_ok, redo_ok;

  assign cfg_ready = 1'b1;

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      history_limit <= LIMIT_RESET;
      byte_budget   <= BUDGET_RESET;
      min_keep      <= MIN_KEEP_RESET;
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == CFG_HISTORY_LIMIT) history_limit <= cfg_data[LIM_W-1:0];
      if (cfg_index == CFG_BYTE_BUDGET)   byte_budget   <= cfg_data;
      if (cfg_index == CFG_MIN_KEEP)      min_keep      <= cfg_data[LIM_W-1:0];
    end
  end

  // ring arithmetic on the past list
  always_comb begin
    tail_raw   = WRAP_W'(past_oldest) + WRAP_W'(past_count);
    newest_raw = tail_raw - WRAP_W'(1);
    tail_idx   = (tail_raw >= WRAP_W'(HISTORY_DEPTH))
               ? IDX_W'(tail_raw - WRAP_W'(HISTORY_DEPTH)) : IDX_W'(tail_raw);
    newest_idx = (newest_raw >= WRAP_W'(HISTORY_DEPTH))
               ? IDX_W'(newest_raw - WRAP_W'(HISTORY_DEPTH)) : IDX_W'(newest_raw);
    oldest_inc = (past_oldest == IDX_W'(HISTORY_DEPTH - 1))
               ? '0 : past_oldest + IDX_W'(1);
  end

  // effective limit and trim decision
  always_comb begin
    eff_limit = CMP_W'(history_limit);
    if (history_limit == '0) eff_limit = CMP_W'(1);
    if (eff_limit > CMP_W'(HISTORY_DEPTH)) eff_limit = CMP_W'(HISTORY_DEPTH);
    past_full   = (past_count >= CNT_W'(HISTORY_DEPTH));
    future_full = (future_count >= CNT_W'(HISTORY_DEPTH));
    undo_ok     = (past_count != '0) && !future_full;
    redo_ok     = (future_count != '0) && !past_full;
    trim_cond   = (past_count != '0)
               && ((CMP_W'(past_count) > eff_limit)
                || ((CMP_W'(past_count) > CMP_W'(min_keep)) && (past_sum > byte_budget)));
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: if (start) state_next = S_DECODE;
      S_DECODE: begin
        unique case (op)
          OP_RESET:  state_next = S_REPLY;
          OP_COMMIT: state_next = past_full ? S_DROP : S_PUSH;
          OP_UNDO:   state_next = undo_ok ? S_UNDO : S_REPLY;
          OP_REDO:   state_next = redo_ok ? S_REDO : S_REPLY;
        endcase
      end
      S_PUSH:  state_next = S_TRIM;
      S_TRIM:  state_next = trim_cond ? S_DROP : S_REPLY;
      S_DROP:  state_next = pushed ? S_TRIM : S_PUSH;
      S_UNDO:  state_next = S_REPLY;
      S_REDO:  state_next = S_REPLY;
      S_REPLY: state_next = S_IDLE;
    endcase
  end

  // control outputs and memory port selection
  always_comb begin
    busy         = (state != S_IDLE);
    done         = (state == S_REPLY);
    past_we      = 1'b0;
    future_we    = 1'b0;
    past_raddr   = past_oldest;
    future_raddr = IDX_W'(future_count - CNT_W'(1));
    unique case (state)
      S_DECODE: if (op == OP_UNDO) past_raddr = newest_idx;
      S_PUSH:   past_we = 1'b1;
      S_UNDO:   future_we = 1'b1;
      S_REDO:   past_we = 1'b1;
      S_IDLE, S_TRIM, S_DROP, S_REPLY: ;
    endcase
  end

  // memories with registered reads
  always_ff @(posedge clk) begin
    if (past_we) past_mem[tail_idx] <= current;
    past_rdata <= past_mem[past_raddr];
  end

  always_ff @(posedge clk) begin
    if (future_we) future_mem[future_count[IDX_W-1:0]] <= current;
    future_rdata <= future_mem[future_raddr];
  end

  // sequencer state and history datapath
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      past_oldest   <= '0;
      past_count    <= '0;
      past_sum      <= '0;
      future_count  <= '0;
      current       <= '0;
      dropped       <= '0;
      result_status <= STATUS_DONE;
      pushed        <= 1'b0;
      op            <= OP_RESET;
    end else begin
      state <= state_next;
      unique case (state)
        S_IDLE: begin
          if (start) begin
            op            <= op_t'(opcode);
            new_handle    <= snapshot_handle;
            new_bytes     <= snapshot_bytes;
            dropped       <= '0;
            pushed        <= 1'b0;
            result_status <= STATUS_DONE;
          end
        end
        S_DECODE: begin
          unique case (op)
            OP_RESET: begin
              past_oldest    <= '0;
              past_count     <= '0;
              past_sum       <= '0;
              future_count   <= '0;
              current.handle <= new_handle;
              current.size   <= new_bytes;
            end
            OP_COMMIT: ;
            OP_UNDO: if (!undo_ok) result_status <= STATUS_NO_UNDO;
            OP_REDO: if (!redo_ok) result_status <= STATUS_NO_REDO;
          endcase
        end
        S_PUSH: begin
          past_count     <= past_count + CNT_W'(1);
          past_sum       <= past_sum + SUM_W'(current.size);
          current.handle <= new_handle;
          current.size   <= new_bytes;
          future_count   <= '0;
          pushed         <= 1'b1;
        end
        S_DROP: begin
          past_sum    <= past_sum - SUM_W'(past_rdata.size);
          past_oldest <= oldest_inc;
          past_count  <= past_count - CNT_W'(1);
          dropped     <= dropped + CNT_W'(1);
        end
        S_UNDO: begin
          future_count <= future_count + CNT_W'(1);
          current      <= past_rdata;
          past_sum     <= past_sum - SUM_W'(past_rdata.size);
          past_count   <= past_count - CNT_W'(1);
        end
        S_REDO: begin
          past_count   <= past_count + CNT_W'(1);
          past_sum     <= past_sum + SUM_W'(current.size);
          current      <= future_rdata;
          future_count <= future_count - CNT_W'(1);
        end
        S_TRIM, S_REPLY: ;
      endcase
    end
  end

  // result beat straight from the state registers
  assign status           = result_status;
  assign current_handle   = current.handle;
  assign current_bytes    = current.size;
  assign past_depth       = past_count;
  assign future_depth     = future_count;
  assign past_total_bytes = past_sum;
  assign dropped_count    = dropped;

endmodule

/* src/burh_checker.sv */
// port-level checker for the bounded undo/redo history unit, with its bind
module burh_checker
  import burh_pkg::*;
(
  input logic             clk,
  input logic             rst,
  input logic             start,
  input logic             busy,
  input logic             done,
  input logic [1:0]       status,
  input logic [CNT_W-1:0] past_depth,
  input logic [CNT_W-1:0] future_depth,
  input logic [CNT_W-1:0] dropped_count
);

  // an accepted command makes the unit busy
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy) else $error("accepted command did not raise busy");

  // the result beat comes only while a command is in flight
  a_done_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> busy) else $error("result beat without a command in flight");

  // one result beat per command
  a_done_single: assert property (@(posedge clk) disable iff (rst)
    done |=> !done && !busy) else $error("result beat longer than one cycle");

  // past plus future never exceed the storage
  a_depth_bound: assert property (@(posedge clk) disable iff (rst)
    done |-> (CNT_W + 1)'(past_depth) + (CNT_W + 1)'(future_depth)
             <= (CNT_W + 1)'(HISTORY_DEPTH))
    else $error("past and future depth exceed the history storage");

  // a refused undo or redo drops nothing
  a_fail_nodrop: assert property (@(posedge clk) disable iff (rst)
    done && (status == STATUS_NO_UNDO || status == STATUS_NO_REDO)
      |-> dropped_count == '0) else $error("refused command reported drops");

endmodule

bind bounded_undo_redo_history_unit burh_checker u_burh_checker (
  .clk           (clk),
  .rst           (rst),
  .start         (start),
  .busy          (busy),
  .done          (done),
  .status        (status),
  .past_depth    (past_depth),
  .future_depth  (future_depth),
  .dropped_count (dropped_count)
);

/* bench/undo_history_checker.sv */
// checker for the history unit: predicts each result beat and compares it with the outputs
module undo_history_checker
  import burh_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    start,
  input  logic                    busy,
  input  logic [1:0]              opcode,
  input  logic [HANDLE_WIDTH-1:0] snapshot_handle,
  input  logic [SIZE_WIDTH-1:0]   snapshot_bytes,
  input  logic                    done,
  input  logic [1:0]              status,
  input  logic [HANDLE_WIDTH-1:0] current_handle,
  input  logic [SIZE_WIDTH-1:0]   current_bytes,
  input  logic [CNT_W-1:0]        past_depth,
  input  logic [CNT_W-1:0]        future_depth,
  input  logic [SUM_W-1:0]        past_total_bytes,
  input  logic [CNT_W-1:0]        dropped_count,
  input  logic                    cfg_valid,
  input  logic                    cfg_ready,
  input  logic [CFG_IDX_W-1:0]    cfg_index,
  input  logic [SUM_W-1:0]        cfg_data,
  output int                      failures,
  output int                      open_results
);

  // one predicted result beat
  typedef struct packed {
    status_t                 st;
    logic [HANDLE_WIDTH-1:0] handle;
    logic [SIZE_WIDTH-1:0]   size;
    logic [CNT_W-1:0]        past_n;
    logic [CNT_W-1:0]        future_n;
    logic [SUM_W-1:0]        total;
    logic [CNT_W-1:0]        dropped;
  } outcome_t;

  // predicted beats waiting for the unit, kept in a small ring
  localparam int PEND_DEPTH = 4;
  outcome_t expected_beats [PEND_DEPTH];
  int       pend_wr, pend_rd;
  int       errors = 0;

  // settings as last written
  logic [LIM_W-1:0] limit_reg;
  logic [SUM_W-1:0] budget_reg;
  logic [LIM_W-1:0] keep_reg;

  // mirrored history: past ring, future stack, current slot
  logic [HANDLE_WIDTH-1:0] past_handle [HISTORY_DEPTH];
  logic [SIZE_WIDTH-1:0]   past_size   [HISTORY_DEPTH];
  logic [HANDLE_WIDTH-1:0] redo_handle [HISTORY_DEPTH];
  logic [SIZE_WIDTH-1:0]   redo_size   [HISTORY_DEPTH];
  int                      oldest, past_count, redo_count;
  logic [SUM_W-1:0]        past_bytes, redo_bytes;
  logic [HANDLE_WIDTH-1:0] cur_handle;
  logic [SIZE_WIDTH-1:0]   cur_size;

  assign failures = errors;

  function automatic void drop_oldest();
    past_bytes = past_bytes - SUM_W'(past_size[oldest]);
    oldest     = (oldest + 1) % HISTORY_DEPTH;
    past_count--;
  endfunction

  function automatic void push_past(logic [HANDLE_WIDTH-1:0] h, logic [SIZE_WIDTH-1:0] s);
    int slot;
    slot = (oldest + past_count) % HISTORY_DEPTH;
    past_handle[slot] = h;
    past_size[slot]   = s;
    past_count++;
    past_bytes = past_bytes + SUM_W'(s);
  endfunction

  // apply one command to the mirrored history and return its result beat
  function automatic outcome_t apply_history_op(op_t op, logic [HANDLE_WIDTH-1:0] h,
                                                logic [SIZE_WIDTH-1:0] s);
    outcome_t res;
    int       lim, newest, dropped;
    res.st  = STATUS_DONE;
    dropped = 0;
    case (op)
      OP_RESET: begin
        oldest     = 0;
        past_count = 0;
        past_bytes = '0;
        redo_count = 0;
        redo_bytes = '0;
        cur_handle = h;
        cur_size   = s;
      end
      OP_COMMIT: begin
        // zero limit acts as one, anything above storage as the storage depth
        lim = (limit_reg == '0) ? 1 : int'(limit_reg);
        if (lim > HISTORY_DEPTH) lim = HISTORY_DEPTH;
        // full past list loses its oldest entry before the push
        if (past_count >= HISTORY_DEPTH) begin
          drop_oldest();
          dropped++;
        end
        push_past(cur_handle, cur_size);
        cur_handle = h;
        cur_size   = s;
        redo_count = 0;
        redo_bytes = '0;
        while (past_count > 0 && (past_count > lim ||
               (past_count > int'(keep_reg) && past_bytes > budget_reg))) begin
          drop_oldest();
          dropped++;
        end
      end
      OP_UNDO: begin
        if (past_count == 0 || redo_count >= HISTORY_DEPTH) begin
          res.st = STATUS_NO_UNDO;
        end else begin
          newest = (oldest + past_count - 1) % HISTORY_DEPTH;
          redo_handle[redo_count] = cur_handle;
          redo_size[redo_count]   = cur_size;
          redo_count++;
          redo_bytes = redo_bytes + SUM_W'(cur_size);
          cur_handle = past_handle[newest];
          cur_size   = past_size[newest];
          past_bytes = past_bytes - SUM_W'(past_size[newest]);
          past_count--;
        end
      end
      default: begin
        // redo never trims
        if (redo_count == 0 || past_count >= HISTORY_DEPTH) begin
          res.st = STATUS_NO_REDO;
        end else begin
          push_past(cur_handle, cur_size);
          redo_count--;
          cur_handle = redo_handle[redo_count];
          cur_size   = redo_size[redo_count];
          redo_bytes = redo_bytes - SUM_W'(redo_size[redo_count]);
        end
      end
    endcase
    res.handle   = cur_handle;
    res.size     = cur_size;
    res.past_n   = CNT_W'(past_count);
    res.future_n = CNT_W'(redo_count);
    res.total    = past_bytes;
    res.dropped  = CNT_W'(dropped);
    return res;
  endfunction

  function automatic int check_field(string name, logic [SUM_W-1:0] want,
                                     logic [SUM_W-1:0] got);
    if (want === got) return 0;
    $display("%0t: %s expected %0h actual %0h", $time, name, want, got);
    return 1;
  endfunction

  // watch the command, result and settings channels
  always @(posedge clk) begin
    outcome_t want;
    if (rst) begin
      limit_reg  = LIMIT_RESET;
      budget_reg = BUDGET_RESET;
      keep_reg   = MIN_KEEP_RESET;
      oldest     = 0;
      past_count = 0;
      past_bytes = '0;
      redo_count = 0;
      redo_bytes = '0;
      cur_handle = '0;
      cur_size   = '0;
      pend_wr    = 0;
      pend_rd    = 0;
      open_results <= 0;
    end else begin
      // result beat against the oldest prediction
      if (done) begin
        if (pend_wr == pend_rd) begin
          $display("%0t: result beat with no command outstanding", $time);
          errors++;
        end else begin
          want = expected_beats[pend_rd % PEND_DEPTH];
          pend_rd++;
          errors += check_field("status", want.st, status);
          errors += check_field("current_handle", want.handle, current_handle);
          errors += check_field("current_bytes", want.size, current_bytes);
          errors += check_field("past_depth", want.past_n, past_depth);
          errors += check_field("future_depth", want.future_n, future_depth);
          errors += check_field("past_total_bytes", want.total, past_total_bytes);
          errors += check_field("dropped_count", want.dropped, dropped_count);
        end
      end
      // settings beat
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_HISTORY_LIMIT: limit_reg  = cfg_data[LIM_W-1:0];
          CFG_BYTE_BUDGET:   budget_reg = cfg_data;
          CFG_MIN_KEEP:      keep_reg   = cfg_data[LIM_W-1:0];
          default: ;
        endcase
      end
      // accepted command
      if (start && !busy) begin
        expected_beats[pend_wr % PEND_DEPTH] =
          apply_history_op(op_t'(opcode), snapshot_handle, snapshot_bytes);
        pend_wr++;
      end
      open_results <= pend_wr - pend_rd;
    end
  end

endmodule

/* bench/bounded_undo_redo_history_unit_test.sv */
// testbench top: drives commands and settings into the history unit and gives the verdict
module bounded_undo_redo_history_unit_test;
  import burh_pkg::*;

  localparam int                   CYCLE_LIMIT = 500000;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE   = 2'd3;
  localparam logic [SUM_W-1:0]     BUDGET_MAX  = '1;

  logic                    clk = 1'b0;
  logic                    rst = 1'b1;
  logic                    start = 1'b0;
  logic [1:0]              opcode = '0;
  logic [HANDLE_WIDTH-1:0] snapshot_handle = '0;
  logic [SIZE_WIDTH-1:0]   snapshot_bytes = '0;
  logic                    cfg_valid = 1'b0;
  logic [CFG_IDX_W-1:0]    cfg_index = '0;
  logic [SUM_W-1:0]        cfg_data = '0;
  logic                    busy, done, cfg_ready;
  logic [1:0]              status;
  logic [HANDLE_WIDTH-1:0] current_handle;
  logic [SIZE_WIDTH-1:0]   current_bytes;
  logic [CNT_W-1:0]        past_depth, future_depth, dropped_count;
  logic [SUM_W-1:0]        past_total_bytes;
  int                      failures, open_results;
  int                      cycle_count = 0;

  always #2 clk = ~clk;

  bounded_undo_redo_history_unit uut (
    .clk, .rst, .start, .busy, .opcode, .snapshot_handle, .snapshot_bytes,
    .done, .status, .current_handle, .current_bytes, .past_depth, .future_depth,
    .past_total_bytes, .dropped_count, .cfg_valid, .cfg_ready, .cfg_index, .cfg_data
  );

  undo_history_checker chk (
    .clk, .rst, .start, .busy, .opcode, .snapshot_handle, .snapshot_bytes,
    .done, .status, .current_handle, .current_bytes, .past_depth, .future_depth,
    .past_total_bytes, .dropped_count, .cfg_valid, .cfg_ready, .cfg_index, .cfg_data,
    .failures, .open_results
  );

  // one command beat; start stays high for the caller to reuse
  task automatic send_cmd(input op_t op, input logic [HANDLE_WIDTH-1:0] h,
                          input logic [SIZE_WIDTH-1:0] b);
    start           <= 1'b1;
    opcode          <= op;
    snapshot_handle <= h;
    snapshot_bytes  <= b;
    do @(posedge clk); while (busy);
  endtask

  task automatic rest(input int n);
    start <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  // hold off until every outstanding result has come back
  task automatic drain();
    start <= 1'b0;
    do @(posedge clk); while (open_results != 0);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [SUM_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
  endtask

  // upper bits above a 7-bit register are ignored, so fill them now and then
  function automatic logic [SUM_W-LIM_W-1:0] filler_bits();
    return $urandom_range(0, 1) ? (SUM_W-LIM_W)'({$urandom, $urandom}) : '0;
  endfunction

  task automatic apply_settings(input logic [LIM_W-1:0] lim, input logic [SUM_W-1:0] budget,
                                input logic [LIM_W-1:0] keep, input bit poke_spare);
    drain();
    write_reg(CFG_HISTORY_LIMIT, {filler_bits(), lim});
    write_reg(CFG_BYTE_BUDGET, budget);
    write_reg(CFG_MIN_KEEP, {filler_bits(), keep});
    if (poke_spare) write_reg(CFG_SPARE, SUM_W'({$urandom, $urandom}));
    cfg_valid <= 1'b0;
  endtask

  function automatic op_t pick_op(input int commit_pct);
    int r;
    r = $urandom_range(0, 99);
    if (r < 3) return OP_RESET;
    if (r < 3 + commit_pct) return OP_COMMIT;
    return ($urandom_range(0, 99) < 55) ? OP_UNDO : OP_REDO;
  endfunction

  function automatic logic [SIZE_WIDTH-1:0] pick_bytes();
    case ($urandom_range(0, 4))
      0:       return '0;
      1:       return '1;
      2:       return SIZE_WIDTH'($urandom_range(0, 255));
      default: return $urandom;
    endcase
  endfunction

  // random commands with optional idle bursts and occasional full drains
  task automatic run_random(input int n, input int commit_pct, input bit idle_on);
    for (int i = 0; i < n; i++) begin
      if (idle_on && $urandom_range(0, 3) == 0) rest($urandom_range(1, 14));
      else if (idle_on && $urandom_range(0, 39) == 0) drain();
      send_cmd(pick_op(commit_pct), HANDLE_WIDTH'($urandom), pick_bytes());
    end
  endtask

  // run limit
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("[bounded_undo_redo_history_unit] ERROR");
    $finish;
  end

  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // directed: empty sources, field extremes, every opcode, future cleared by commit
    send_cmd(OP_UNDO, '0, '0);
    send_cmd(OP_REDO, '1, '1);
    send_cmd(OP_RESET, '1, '1);
    send_cmd(OP_COMMIT, '0, '0);
    send_cmd(OP_COMMIT, '1, '1);
    send_cmd(OP_COMMIT, 16'h1234, 32'h1);
    send_cmd(OP_UNDO, '0, '0);
    send_cmd(OP_UNDO, '1, '1);
    send_cmd(OP_REDO, '0, '0);
    send_cmd(OP_UNDO, '0, '0);
    send_cmd(OP_UNDO, '0, '0);
    send_cmd(OP_UNDO, '0, '0);
    send_cmd(OP_UNDO, '0, '0);
    send_cmd(OP_REDO, '0, '0);
    send_cmd(OP_REDO, '0, '0);
    send_cmd(OP_UNDO, '0, '0);
    send_cmd(OP_COMMIT, 16'hAAAA, 32'h5555_5555);
    send_cmd(OP_REDO, '0, '0);
    send_cmd(OP_RESET, '0, '0);
    send_cmd(OP_COMMIT, 16'h5555, 32'hAAAA_AAAA);
    send_cmd(OP_UNDO, '0, '0);
    send_cmd(OP_REDO, '0, '0);

    // zero limit acts as one
    apply_settings(7'd0, BUDGET_MAX, 7'd1, 1'b0);
    run_random(40, 50, 1'b1);
    // limit above storage, commit-heavy so the past list fills up
    apply_settings(7'd100, BUDGET_MAX, 7'd0, 1'b0);
    run_random(100, 92, 1'b1);
    // tight budget with a small keep floor
    apply_settings(7'd4, 38'h2_0000_0000, 7'd2, 1'b1);
    run_random(60, 55, 1'b1);
    // zero budget, nothing kept
    apply_settings(7'($urandom_range(1, 64)), '0, 7'd0, 1'b0);
    run_random(50, 50, 1'b1);
    // keep floor at full depth overrides the budget
    apply_settings(7'd64, 38'h1_8000_0000, 7'd64, 1'b0);
    run_random(50, 80, 1'b1);
    // random settings; the last stretch runs without gaps
    for (int p = 0; p < 4; p++) begin
      apply_settings(7'($urandom), SUM_W'($urandom) << $urandom_range(0, 6),
                     7'($urandom_range(0, 8)), 1'b0);
      run_random(45, 60, p < 3);
    end

    drain();
    rest(40);
    if (failures == 0) begin
      $display("[bounded_undo_redo_history_unit] OK");
    end else begin
      $display("[bounded_undo_redo_history_unit] ERROR");
    end
    $finish;
  end

endmodule
